// ----- hw/rtl/wfc_pkg.sv -----
// Shared types, constants and helpers for the waypoint follower controller.
// No dependencies.
package wfc_pkg;

    localparam int W      = 36;
    localparam int IDX_W  = 5;
    localparam int CFG_IW = 3;

    localparam logic [1:0] OP_STORE = 2'd0;
    localparam logic [1:0] OP_POSE  = 2'd1;
    localparam logic [1:0] OP_TICK  = 2'd2;

    localparam logic [2:0] STAT_WAITING   = 3'd0;
    localparam logic [2:0] STAT_PATH_DONE = 3'd1;
    localparam logic [2:0] STAT_MOVING    = 3'd2;
    localparam logic [2:0] STAT_REACHED   = 3'd3;
    localparam logic [2:0] STAT_GOAL      = 3'd4;
    localparam logic [2:0] STAT_STORED    = 3'd5;
    localparam logic [2:0] STAT_POSE_SET  = 3'd6;

    localparam logic [CFG_IW-1:0] CFG_GOAL_X     = 3'd0;
    localparam logic [CFG_IW-1:0] CFG_GOAL_Y     = 3'd1;
    localparam logic [CFG_IW-1:0] CFG_GOAL_EN    = 3'd2;
    localparam logic [CFG_IW-1:0] CFG_WP_COUNT   = 3'd3;
    localparam logic [CFG_IW-1:0] CFG_STOP_RAD   = 3'd4;
    localparam logic [CFG_IW-1:0] CFG_MAX_SPEED  = 3'd5;
    localparam logic [CFG_IW-1:0] CFG_GAIN       = 3'd6;

    localparam logic signed [16:0] KINV       = 17'sd39797;
    localparam logic signed [11:0] YAW_K      = 12'sd1043;
    localparam logic [31:0]        HALF_TURN  = 32'h8000_0000;

    typedef struct packed {
        logic [1:0]         opcode;
        logic [7:0]         slot;
        logic signed [31:0] coord_x;
        logic signed [31:0] coord_y;
        logic [15:0]        heading;
    } t_wfc_in;

    typedef struct packed {
        logic [2:0]         status;
        logic [19:0]        linear_speed;
        logic signed [31:0] angular_rate;
        logic signed [31:0] pose_x_out;
        logic signed [31:0] pose_y_out;
        logic [15:0]        pose_yaw_out;
        logic [8:0]         path_position;
    } t_wfc_out;

    typedef struct packed {
        logic                start;
        logic                rotate;
        logic signed [W-1:0] x;
        logic signed [W-1:0] y;
        logic [31:0]         ang;
    } t_cordic_req;

    typedef struct packed {
        logic                done;
        logic signed [W-1:0] x;
        logic signed [W-1:0] y;
        logic [31:0]         z;
    } t_cordic_rsp;

    typedef enum logic [3:0] {
        S_IDLE, S_DECODE, S_RD, S_V1, S_M1, S_V2, S_M2,
        S_RS, S_ROT, S_P1, S_P2, S_DONE
    } t_state;

    function automatic logic [31:0] cordic_atan(input logic [IDX_W-1:0] i);
        logic [31:0] a;
        unique case (i)
            5'd0:  a = 32'd536870912;
            5'd1:  a = 32'd316933406;
            5'd2:  a = 32'd167458907;
            5'd3:  a = 32'd85004756;
            5'd4:  a = 32'd42667331;
            5'd5:  a = 32'd21354465;
            5'd6:  a = 32'd10679838;
            5'd7:  a = 32'd5340245;
            5'd8:  a = 32'd2670163;
            5'd9:  a = 32'd1335087;
            5'd10: a = 32'd667544;
            5'd11: a = 32'd333772;
            5'd12: a = 32'd166886;
            5'd13: a = 32'd83443;
            5'd14: a = 32'd41722;
            5'd15: a = 32'd20861;
            5'd16: a = 32'd10430;
            5'd17: a = 32'd5215;
            5'd18: a = 32'd2608;
            5'd19: a = 32'd1304;
            5'd20: a = 32'd652;
            5'd21: a = 32'd326;
            5'd22: a = 32'd163;
            5'd23: a = 32'd81;
            default: a = 32'd0;
        endcase
        return a;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > 64'sd2147483647) begin
            r = 32'sh7FFF_FFFF;
        end else if (v < -64'sd2147483648) begin
            r = 32'sh8000_0000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

// ----- hw/rtl/wfc_wp_mem.sv -----
// Waypoint table: one write port, one registered read port, x and y per entry.
// Depends on nothing.
module wfc_wp_mem #(
    parameter int DEPTH = 256,
    parameter int AW    = 8
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [63:0]   i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [63:0]   o_rdata
);
    logic [63:0] r_mem [DEPTH];
    logic [63:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ----- hw/rtl/wfc_cordic.sv -----
// Iterative CORDIC unit, one micro-rotation per cycle, vectoring or rotation.
// Depends on wfc_pkg.
module wfc_cordic #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  wfc_pkg::t_cordic_req i_req,
    output wfc_pkg::t_cordic_rsp o_rsp
);
    import wfc_pkg::*;

    logic signed [W-1:0] r_x, r_y, n_x0, n_y0;
    logic [31:0]         r_z, n_z0;
    logic [IDX_W-1:0]    r_i;
    logic                r_busy, r_done, r_rot;
    logic signed [W-1:0] xs, ys;
    logic [31:0]         atan_v;
    logic                cw, flip;

    always_comb begin
        flip = 1'b0;
        n_x0 = i_req.x;
        n_y0 = i_req.y;
        n_z0 = 32'd0;
        if (i_req.rotate) begin
            flip = (i_req.ang[31:30] == 2'b01) || (i_req.ang[31:30] == 2'b10);
            n_y0 = '0;
            n_x0 = flip ? -i_req.x : i_req.x;
            n_z0 = flip ? (i_req.ang - HALF_TURN) : i_req.ang;
        end else begin
            flip = i_req.x[W-1];
            n_x0 = flip ? -i_req.x : i_req.x;
            n_y0 = flip ? -i_req.y : i_req.y;
            n_z0 = flip ? HALF_TURN : 32'd0;
        end
    end

    assign xs     = r_x >>> r_i;
    assign ys     = r_y >>> r_i;
    assign atan_v = cordic_atan(r_i);
    assign cw     = r_rot ? r_z[31] : (!r_y[W-1] && (|r_y));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else if (i_req.start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
        end else if (r_busy && (r_i == IDX_W'(CORDIC_STEPS - 1))) begin
            r_busy <= 1'b0;
            r_done <= 1'b1;
        end else begin
            r_done <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_x   <= n_x0;
            r_y   <= n_y0;
            r_z   <= n_z0;
            r_rot <= i_req.rotate;
            r_i   <= '0;
        end else if (r_busy) begin
            if (cw) begin
                r_x <= r_x + ys;
                r_y <= r_y - xs;
                r_z <= r_z + atan_v;
            end else begin
                r_x <= r_x - ys;
                r_y <= r_y + xs;
                r_z <= r_z - atan_v;
            end
            r_i <= r_i + 1'b1;
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.x    = r_x;
    assign o_rsp.y    = r_y;
    assign o_rsp.z    = r_z;
endmodule

// ----- hw/rtl/waypoint_follower_controller_top.sv -----
// Top level of the waypoint follower controller: sequencer, state and arithmetic.
// Depends on wfc_pkg, wfc_wp_mem and wfc_cordic.
//
// Usage:
//  Request channel i_in / i_in_valid / o_in_stall carries one command: store a
//  waypoint, set the pose, or run a control tick. Result channel o_out /
//  o_out_valid / i_out_stall returns exactly one result per request.
//  Configuration writes use i_cfg_valid / o_cfg_ready with i_cfg_index and
//  i_cfg_data; write them only while no request is in flight.
//  One request is worked at a time. Store, pose and idle ticks pass through
//  S_DECODE and S_DONE only. A tick that steers makes three passes through
//  the shared CORDIC unit (waypoint bearing, goal distance, motion rotation).
//  The waypoint table is a single-port-write synchronous memory; its entries
//  hold no defined value until written.
//  Reset clears the pose, path cursor and configuration to their defaults.
//  A finished result waits in the output register while the receiver stalls;
//  the next request is accepted meanwhile and holds in its last state until
//  the output register frees.
module waypoint_follower_controller_top #(
    parameter int WAYPOINT_DEPTH = 256,
    parameter int CORDIC_STEPS   = 16,
    parameter int FRAC_BITS      = 16
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  wfc_pkg::t_wfc_in           i_in,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output wfc_pkg::t_wfc_out          o_out,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [wfc_pkg::CFG_IW-1:0] i_cfg_index,
    input  logic [31:0]                i_cfg_data
);
    import wfc_pkg::*;

    localparam int AW = (WAYPOINT_DEPTH > 1) ? $clog2(WAYPOINT_DEPTH) : 1;
    localparam longint TWO_PI_L =
        (64'd26986075409 + (64'd1 << (31 - FRAC_BITS))) >> (32 - FRAC_BITS);
    localparam longint DT_L = ((64'd1 << FRAC_BITS) + 64'd5) / 64'd10;
    localparam logic signed [28:0] TWO_PI_S = 29'(TWO_PI_L);
    localparam logic signed [23:0] DT_S     = 24'(DT_L);

    t_state r_state, n_state;

    logic signed [31:0] r_goal_x, r_goal_y, r_pos_x, r_pos_y;
    logic               r_goal_en, r_pose_valid;
    logic [8:0]         r_wp_count, r_cursor;
    logic [19:0]        r_stop_rad, r_max_speed, r_speed;
    logic [15:0]        r_gain, r_yaw;

    t_wfc_in            r_item;
    logic [2:0]         r_status;
    logic signed [31:0] r_rate;
    logic [31:0]        r_ang;
    logic signed [52:0] r_prod_x, r_prod_y;
    logic signed [32:0] r_ge;
    logic signed [61:0] r_rate_raw;
    logic signed [43:0] r_yaw_prod;
    logic signed [59:0] r_mot_x, r_mot_y;
    logic               r_out_valid;
    t_wfc_out           r_out;

    t_cordic_req        c_req;
    t_cordic_rsp        c_rsp;
    logic               c_mem_we, c_out_load;
    logic [63:0]        mem_rdata;
    logic [12:0]        slot_ext, cursor_ext;

    logic               tick_ready, path_done;
    logic signed [52:0] rnd_x, rnd_y;
    logic signed [36:0] mag_q, tx, ty, stop_s, max_s;
    logic [31:0]        ang_r;
    logic signed [15:0] err;
    logic signed [32:0] ge;
    logic signed [61:0] rate_sum, rate_rnd;
    logic signed [43:0] yaw_sum, yaw_shift;
    logic signed [59:0] mot_sum_x, mot_sum_y, step_x, step_y;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    assign slot_ext   = 13'(r_item.slot);
    assign cursor_ext = 13'(r_cursor);
    assign tick_ready = r_pose_valid && r_goal_en;
    assign path_done  = (r_cursor >= r_wp_count) || (32'(r_cursor) >= 32'(WAYPOINT_DEPTH));

    assign rnd_x  = r_prod_x + (53'sd1 <<< 15);
    assign rnd_y  = r_prod_y + (53'sd1 <<< 15);
    assign mag_q  = rnd_x[52:16];
    assign tx     = rnd_x[52:16];
    assign ty     = rnd_y[52:16];
    assign stop_s = $signed({17'd0, r_stop_rad});
    assign max_s  = $signed({17'd0, r_max_speed});
    assign ang_r  = r_ang + 32'h0000_8000;
    assign err    = $signed(ang_r[31:16] - r_yaw);
    assign ge     = $signed({1'b0, r_gain}) * err;

    assign rate_sum  = r_rate_raw + (62'sd1 <<< 23);
    assign rate_rnd  = rate_sum >>> 24;
    assign yaw_sum   = r_yaw_prod + (44'sd1 <<< (FRAC_BITS - 1));
    assign yaw_shift = yaw_sum >>> FRAC_BITS;
    assign mot_sum_x = r_mot_x + (60'sd1 <<< (FRAC_BITS + 7));
    assign mot_sum_y = r_mot_y + (60'sd1 <<< (FRAC_BITS + 7));
    assign step_x    = mot_sum_x >>> (FRAC_BITS + 8);
    assign step_y    = mot_sum_y >>> (FRAC_BITS + 8);

    wfc_wp_mem #(
        .DEPTH (WAYPOINT_DEPTH),
        .AW    (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (c_mem_we),
        .i_waddr (slot_ext[AW-1:0]),
        .i_wdata ({r_item.coord_y, r_item.coord_x}),
        .i_raddr (cursor_ext[AW-1:0]),
        .o_rdata (mem_rdata)
    );

    wfc_cordic #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (c_req),
        .o_rsp   (c_rsp)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) n_state = S_DECODE;
            end
            S_DECODE: begin
                if (r_item.opcode == OP_TICK && tick_ready && !path_done) begin
                    n_state = S_RD;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_RD:   n_state = S_V1;
            S_V1: begin
                if (c_rsp.done) n_state = S_M1;
            end
            S_M1:   n_state = S_V2;
            S_V2: begin
                if (c_rsp.done) n_state = S_M2;
            end
            S_M2:   n_state = S_RS;
            S_RS:   n_state = S_ROT;
            S_ROT: begin
                if (c_rsp.done) n_state = S_P1;
            end
            S_P1:   n_state = S_P2;
            S_P2:   n_state = S_DONE;
            S_DONE: begin
                if (c_out_load) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        c_req.start  = 1'b0;
        c_req.rotate = 1'b0;
        c_req.x      = W'($signed(mem_rdata[31:0])) - W'(r_pos_x);
        c_req.y      = W'($signed(mem_rdata[63:32])) - W'(r_pos_y);
        c_req.ang    = {r_yaw, 16'd0};
        c_mem_we     = 1'b0;
        c_out_load   = 1'b0;
        unique case (r_state)
            S_DECODE: begin
                c_mem_we = (r_item.opcode == OP_STORE) &&
                           (32'(r_item.slot) < 32'(WAYPOINT_DEPTH));
            end
            S_RD: begin
                c_req.start = 1'b1;
            end
            S_M1: begin
                c_req.start = 1'b1;
                c_req.x     = W'(r_goal_x) - W'(r_pos_x);
                c_req.y     = W'(r_goal_y) - W'(r_pos_y);
            end
            S_RS: begin
                c_req.start  = 1'b1;
                c_req.rotate = 1'b1;
                c_req.x      = W'($signed({1'b0, r_speed, 8'd0}));
                c_req.y      = '0;
            end
            S_DONE: begin
                c_out_load = !r_out_valid || !i_out_stall;
            end
            default: begin
                c_req.start = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_goal_x     <= '0;
            r_goal_y     <= '0;
            r_goal_en    <= 1'b0;
            r_wp_count   <= '0;
            r_stop_rad   <= 20'd6554;
            r_max_speed  <= 20'd32768;
            r_gain       <= 16'd512;
            r_pos_x      <= '0;
            r_pos_y      <= '0;
            r_yaw        <= '0;
            r_cursor     <= '0;
            r_pose_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_GOAL_X:    r_goal_x    <= $signed(i_cfg_data);
                    CFG_GOAL_Y:    r_goal_y    <= $signed(i_cfg_data);
                    CFG_GOAL_EN:   r_goal_en   <= i_cfg_data[0];
                    CFG_WP_COUNT:  r_wp_count  <= i_cfg_data[8:0];
                    CFG_STOP_RAD:  r_stop_rad  <= i_cfg_data[19:0];
                    CFG_MAX_SPEED: r_max_speed <= i_cfg_data[19:0];
                    CFG_GAIN:      r_gain      <= i_cfg_data[15:0];
                    default: ;
                endcase
            end
            if (c_out_load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (r_state == S_DECODE) begin
                if (r_item.opcode == OP_STORE) begin
                    r_cursor <= '0;
                end else if (r_item.opcode == OP_POSE) begin
                    r_pos_x      <= r_item.coord_x;
                    r_pos_y      <= r_item.coord_y;
                    r_yaw        <= r_item.heading;
                    r_pose_valid <= 1'b1;
                end
            end
            if (r_state == S_M1 && !(mag_q > stop_s)) begin
                r_cursor <= r_cursor + 9'd1;
            end
            if (r_state == S_P2) begin
                r_pos_x <= sat32(64'(step_x) + 64'(r_pos_x));
                r_pos_y <= sat32(64'(step_y) + 64'(r_pos_y));
                r_yaw   <= r_yaw + yaw_shift[15:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_in_valid) begin
            r_item <= i_in;
        end
        if (c_out_load) begin
            r_out.status        <= r_status;
            r_out.linear_speed  <= r_speed;
            r_out.angular_rate  <= r_rate;
            r_out.pose_x_out    <= r_pos_x;
            r_out.pose_y_out    <= r_pos_y;
            r_out.pose_yaw_out  <= r_yaw;
            r_out.path_position <= r_cursor;
        end
        unique case (r_state)
            S_DECODE: begin
                r_speed <= '0;
                r_rate  <= '0;
                unique case (r_item.opcode)
                    OP_STORE: r_status <= STAT_STORED;
                    OP_POSE:  r_status <= STAT_POSE_SET;
                    OP_TICK: begin
                        if (!tick_ready) begin
                            r_status <= STAT_WAITING;
                        end else if (path_done) begin
                            r_status <= STAT_PATH_DONE;
                        end else begin
                            r_status <= STAT_MOVING;
                        end
                    end
                    default:  r_status <= STAT_WAITING;
                endcase
            end
            S_V1: begin
                if (c_rsp.done) begin
                    r_prod_x <= c_rsp.x * KINV;
                    r_ang    <= c_rsp.z;
                end
            end
            S_M1: begin
                if (mag_q > stop_s) begin
                    r_status <= STAT_MOVING;
                    r_speed  <= (mag_q < max_s) ? mag_q[19:0] : r_max_speed;
                    r_ge     <= ge;
                end else begin
                    r_status <= STAT_REACHED;
                    r_ge     <= '0;
                end
            end
            S_V2: begin
                r_rate_raw <= r_ge * TWO_PI_S;
                if (c_rsp.done) begin
                    r_prod_x <= c_rsp.x * KINV;
                end
            end
            S_M2: begin
                if (mag_q < stop_s) begin
                    r_status <= STAT_GOAL;
                    r_speed  <= '0;
                    r_rate   <= '0;
                end else if (r_status == STAT_MOVING) begin
                    r_rate <= sat32(64'(rate_rnd));
                end
            end
            S_ROT: begin
                if (c_rsp.done) begin
                    r_prod_x   <= c_rsp.x * KINV;
                    r_prod_y   <= c_rsp.y * KINV;
                    r_yaw_prod <= r_rate * YAW_K;
                end
            end
            S_P1: begin
                r_mot_x <= tx * DT_S;
                r_mot_y <= ty * DT_S;
            end
            default: ;
        endcase
    end
endmodule
